// ----- hdl/cnhd_pkg.sv -----
// Package with the shared types and constants of the chained name hash directory.
`timescale 1ns / 1ps

package cnhd_pkg;

    localparam int NAME_BYTES     = 8;
    localparam int NAME_W         = 64;
    localparam int MODE_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int ENTRY_INDEX_W  = 12;
    localparam int BUCKET_COUNT_W = 13;
    localparam int HASH_W         = 32;

    localparam logic [HASH_W-1:0]         HASH_SEED        = 32'd5381;
    localparam logic [BUCKET_COUNT_W-1:0] BUCKET_COUNT_RST = 13'd4096;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_DIV,
        S_HEAD_RD,
        S_HEAD_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_DONE
    } t_state;

endpackage

// ----- hdl/cnhd_intf.sv -----
// Request and response channel interfaces of the chained name hash directory.
`timescale 1ns / 1ps

interface cnhd_req_if import cnhd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [NAME_W-1:0] entry_name;

    modport source (output valid, output mode, output entry_name, input ready);
    modport sink   (input valid, input mode, input entry_name, output ready);
endinterface

interface cnhd_rsp_if import cnhd_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ENTRY_INDEX_W-1:0] entry_index;
    logic [STATUS_W-1:0]      status;

    modport source (output valid, output entry_index, output status, input ready);
    modport sink   (input valid, input entry_index, input status, output ready);
endinterface

// ----- hdl/cnhd_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module cnhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/chained_name_hash_directory.sv -----
// Top level of the chained name hash directory.
`timescale 1ns / 1ps

// A directory of up to MAX_ENTRIES eight-character names, looked up without regard to case
// through chained hashing. Each request word loads a name, looks one up or clears the
// directory (any other mode is answered with a miss), and gives exactly one response word.
// A load into a full directory is refused with a full status. Otherwise a load or lookup
// hashes the name, forms the bucket remainder (one quotient bit a cycle), reads the bucket
// head and gives the response; a lookup then reads its chain entry by entry through the
// entry memory. A clear sweeps the bucket head memory one entry a cycle. After reset the
// same sweep runs before the first request word is taken; configuration writes are taken
// at any time the block is idle.
module chained_name_hash_directory
    import cnhd_pkg::*;
#(
    parameter int MAX_ENTRIES = 4096
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [BUCKET_COUNT_W-1:0] i_cfg_wdata,
    cnhd_req_if.sink                  i_req,
    cnhd_rsp_if.source                o_rsp
);

    localparam int IW = $clog2(MAX_ENTRIES);
    localparam int EW = $clog2(MAX_ENTRIES + 1);
    localparam int HEAD_W  = IW + 1;
    localparam int ENTRY_W = NAME_W + IW + 1;

    function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
        logic [NAME_W-1:0] res;
        logic [7:0]        c;
        logic              stop;
        res  = '0;
        stop = 1'b0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            c = raw[8*k +: 8];
            if (c == 8'h00) begin
                stop = 1'b1;
            end
            if (!stop) begin
                if (c >= 8'h61 && c <= 8'h7A) begin
                    c = c - 8'h20;
                end
                res[8*k +: 8] = c;
            end
        end
        return res;
    endfunction

    t_state                    r_state, n_state;
    logic [MODE_W-1:0]         r_mode, n_mode;
    logic [NAME_W-1:0]         r_name, n_name;
    logic [EW-1:0]             r_e, n_e;
    logic [EW-1:0]             r_loaded, n_loaded;
    logic [BUCKET_COUNT_W-1:0] r_bc;
    logic [HASH_W-1:0]         r_hash, n_hash;
    logic [4:0]                r_cnt, n_cnt;
    logic [EW-1:0]             r_rem, n_rem;
    logic [IW-1:0]             r_cur, n_cur;
    logic [IW-1:0]             r_clr, n_clr;
    logic                      r_init, n_init;
    logic [IW-1:0]             r_res_idx, n_res_idx;
    logic [STATUS_W-1:0]       r_res_st, n_res_st;
    logic                      r_ov, n_ov;
    logic [ENTRY_INDEX_W-1:0]  r_oidx, n_oidx;
    logic [STATUS_W-1:0]       r_ost, n_ost;

    logic               head_we, head_re;
    logic [IW-1:0]      head_waddr;
    logic [HEAD_W-1:0]  head_wdata, head_rdata;
    logic               ent_we, ent_re;
    logic [ENTRY_W-1:0] ent_wdata, ent_rdata;

    logic [31:0]   bc32;
    logic [EW-1:0] eff;
    logic [7:0]    hbyte;
    logic [EW:0]   trial;
    logic [NAME_W-1:0] ent_name;
    logic              ent_lvalid;
    logic [IW-1:0]     ent_next;

    cnhd_ram #(.WIDTH(HEAD_W), .DEPTH(MAX_ENTRIES)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (r_rem[IW-1:0]),
        .o_rdata (head_rdata)
    );

    cnhd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_loaded[IW-1:0]),
        .i_wdata (ent_wdata),
        .i_re    (ent_re),
        .i_raddr (r_cur),
        .o_rdata (ent_rdata)
    );

    assign ent_name   = ent_rdata[ENTRY_W-1 -: NAME_W];
    assign ent_lvalid = ent_rdata[IW];
    assign ent_next   = ent_rdata[IW-1:0];

    assign bc32 = 32'(r_bc);
    always_comb begin
        if (bc32 == 32'd0) begin
            eff = EW'(1);
        end else if (bc32 > 32'(MAX_ENTRIES)) begin
            eff = EW'(MAX_ENTRIES);
        end else begin
            eff = EW'(bc32);
        end
    end

    assign hbyte = r_name[{r_cnt[2:0], 3'b000} +: 8];
    assign trial = {r_rem, r_hash[HASH_W-1]};

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.entry_index = r_oidx;
    assign o_rsp.status      = r_ost;

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_name    = r_name;
        n_e       = r_e;
        n_loaded  = r_loaded;
        n_hash    = r_hash;
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_cur     = r_cur;
        n_clr     = r_clr;
        n_init    = r_init;
        n_res_idx = r_res_idx;
        n_res_st  = r_res_st;
        n_ov      = r_ov & ~o_rsp.ready;
        n_oidx    = r_oidx;
        n_ost     = r_ost;
        head_we    = 1'b0;
        head_re    = 1'b0;
        head_waddr = r_clr;
        head_wdata = '0;
        ent_we     = 1'b0;
        ent_re     = 1'b0;
        ent_wdata  = {r_name, head_rdata};

        case (r_state)
            S_CLEAR: begin
                head_we  = 1'b1;
                n_loaded = '0;
                n_clr    = r_clr + IW'(1);
                if (r_clr == IW'(MAX_ENTRIES - 1)) begin
                    n_clr = '0;
                    if (r_init) begin
                        n_init  = 1'b0;
                        n_state = S_IDLE;
                    end else begin
                        n_res_idx = '0;
                        n_res_st  = ST_OK;
                        n_state   = S_DONE;
                    end
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode    = i_req.mode;
                    n_name    = normalize(i_req.entry_name);
                    n_e       = eff;
                    n_hash    = HASH_SEED;
                    n_cnt     = '0;
                    n_res_idx = '0;
                    if (i_req.mode == MODE_CLEAR) begin
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end else if (i_req.mode != MODE_LOAD && i_req.mode != MODE_LOOKUP) begin
                        n_res_st = ST_MISS;
                        n_state  = S_DONE;
                    end else if (i_req.mode == MODE_LOAD && r_loaded >= eff) begin
                        n_res_st = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hbyte != 8'h00) begin
                    n_hash = ((r_hash << 5) ^ r_hash) ^ HASH_W'(hbyte);
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd7) begin
                    n_cnt   = '0;
                    n_rem   = '0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (trial >= {1'b0, r_e}) begin
                    n_rem = EW'(trial - {1'b0, r_e});
                end else begin
                    n_rem = EW'(trial);
                end
                n_hash = r_hash << 1;
                n_cnt  = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_cnt   = '0;
                    n_state = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                head_re = 1'b1;
                n_state = S_HEAD_CHK;
            end
            S_HEAD_CHK: begin
                if (r_mode == MODE_LOAD) begin
                    ent_we     = 1'b1;
                    head_we    = 1'b1;
                    head_waddr = r_rem[IW-1:0];
                    head_wdata = {1'b1, r_loaded[IW-1:0]};
                    n_res_idx  = r_loaded[IW-1:0];
                    n_res_st   = ST_OK;
                    n_loaded   = r_loaded + EW'(1);
                    n_state    = S_DONE;
                end else if (!head_rdata[IW]) begin
                    n_res_st = ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    n_cur   = head_rdata[IW-1:0];
                    n_state = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                ent_re  = 1'b1;
                n_state = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (ent_name == r_name) begin
                    n_res_idx = r_cur;
                    n_res_st  = ST_OK;
                    n_state   = S_DONE;
                end else if (!ent_lvalid) begin
                    n_res_st = ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    n_cur   = ent_next;
                    n_state = S_WALK_RD;
                end
            end
            S_DONE: begin
                if (!n_ov) begin
                    n_ov    = 1'b1;
                    n_oidx  = ENTRY_INDEX_W'(r_res_idx);
                    n_ost   = r_res_st;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_init   <= 1'b1;
            r_clr    <= '0;
            r_loaded <= '0;
            r_ov     <= 1'b0;
            r_bc     <= BUCKET_COUNT_RST;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_clr    <= n_clr;
            r_loaded <= n_loaded;
            r_ov     <= n_ov;
            if (i_cfg_we) begin
                r_bc <= i_cfg_wdata;
            end
        end
        r_mode    <= n_mode;
        r_name    <= n_name;
        r_e       <= n_e;
        r_hash    <= n_hash;
        r_cnt     <= n_cnt;
        r_rem     <= n_rem;
        r_cur     <= n_cur;
        r_res_idx <= n_res_idx;
        r_res_st  <= n_res_st;
        r_oidx    <= n_oidx;
        r_ost     <= n_ost;
    end

endmodule
